// ----- design/fcpr_pkg.sv -----
// Shared types, constants and helper functions for the file chunk packet receiver.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package fcpr_pkg;

    // Default limits handed down from the top level.
    localparam int unsigned DEF_MAX_CHUNK = 32;
    localparam int unsigned DEF_MAX_NAME  = 31;

    // Packet layout.
    localparam int unsigned START_FIXED = 19;
    localparam int unsigned DATA_FIXED  = 18;
    localparam int unsigned END_LEN     = 18;
    localparam int unsigned FORMAT_LEN  = 10;
    localparam int unsigned HDR_FIRST   = 4;
    localparam int unsigned HDR_N       = 15;

    // CRC-16/CCITT-FALSE.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Magic bytes, index 0 first on the link: 'J' 'P' 'G' 'U'.
    localparam logic [3:0][7:0] MAGIC = {8'h55, 8'h47, 8'h50, 8'h4A};

    // Depth of the result queue.
    localparam int unsigned OUT_DEPTH = 4;

    // Configuration register reset values.
    localparam logic [7:0] RST_VERSION = 8'd1;
    localparam logic [7:0] RST_START   = 8'd1;
    localparam logic [7:0] RST_DATA    = 8'd2;
    localparam logic [7:0] RST_END     = 8'd3;
    localparam logic [7:0] RST_FORMAT  = 8'd4;

    typedef enum logic [2:0] {
        CFG_VERSION = 3'd0,
        CFG_START   = 3'd1,
        CFG_DATA    = 3'd2,
        CFG_END     = 3'd3,
        CFG_FORMAT  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_NACK = 2'd1,
        KIND_DATA = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_CRC    = 3'd1,
        STAT_PARAM  = 3'd2,
        STAT_SEQ    = 3'd3,
        STAT_OFFSET = 3'd4,
        STAT_FILE   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_READ  = 2'd1,
        S_WRITE = 2'd2,
        S_REPLY = 2'd3
    } back_state_t;

    typedef struct packed {
        logic [7:0] version;
        logic [7:0] start_code;
        logic [7:0] data_code;
        logic [7:0] end_code;
        logic [7:0] format_code;
    } cfg_t;

    // One complete packet as handed from the parser to the executor.
    typedef struct packed {
        logic [7:0]  ver;
        logic [7:0]  cmd;
        logic [15:0] id;
        logic [31:0] w8;
        logic [31:0] w12;
        logic [15:0] w16;
        logic [7:0]  b18;
        logic [7:0]  len;
        logic        crc_ok;
    } desc_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] file_id;
        logic [31:0] seq;
        status_t     status;
        logic [7:0]  data_byte;
        logic [31:0] byte_offset;
        logic        last;
        logic        receiving;
    } result_t;

    // One byte of the CRC, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/fcpr_front.sv -----
// Parser front end: magic hunt, length decode, running CRC, header capture,
// payload memory and the two-slot packet queue. Depends on fcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcpr_front #(
    parameter int unsigned MAX_CHUNK = fcpr_pkg::DEF_MAX_CHUNK,
    parameter int unsigned MAX_NAME  = fcpr_pkg::DEF_MAX_NAME,
    parameter int unsigned PW        = $clog2(MAX_CHUNK + 2)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            push,
    output logic                 full,
    input  wire fcpr_pkg::cfg_t  cfg,
    output logic                 desc_valid,
    output fcpr_pkg::desc_t      desc,
    input  wire logic            desc_pop,
    input  wire logic [PW-1:0]   pay_idx,
    output logic [7:0]           pay_data
);
    import fcpr_pkg::*;

    localparam int unsigned STORE_CAP = DATA_FIXED + MAX_CHUNK + 2;
    localparam int unsigned START_MAX = START_FIXED + 2 + MAX_NAME;
    localparam int unsigned MAX_LEN   = (STORE_CAP > START_MAX) ? STORE_CAP : START_MAX;
    localparam int unsigned CNT_W     = $clog2(MAX_LEN + 1);
    localparam int unsigned MEM_DEPTH = 2 * (1 << PW);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] exp_reg, exp_next;
    logic [15:0]      crc0_reg, crc0_next;
    logic [15:0]      crc1_reg;
    logic [7:0]       prev_reg;
    logic [7:0]       hdr_reg [HDR_N];
    logic [7:0]       hdr_next [HDR_N];
    logic [7:0]       pay_mem [MEM_DEPTH];
    logic [7:0]       pay_data_reg;
    desc_t            slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       q_cnt_reg;

    logic             accept;
    logic [CNT_W-1:0] cnt_eff, exp_eff, n_cnt;
    logic [15:0]      crc_src;
    logic [7:0]       cmd, nl;
    logic [15:0]      pl;
    logic             drop, done;
    desc_t            desc_new;

    assign full       = (q_cnt_reg == 2'd2);
    assign accept     = push && !full;
    assign desc_valid = (q_cnt_reg != 2'd0);
    assign desc       = slot_reg[rd_ptr_reg];
    assign pay_data   = pay_data_reg;

    // Byte parser: hunt, header capture, length decode.
    always_comb
    begin
        cnt_eff = (count_reg >= CNT_W'(STORE_CAP)) ? '0 : count_reg;
        exp_eff = (count_reg >= CNT_W'(STORE_CAP)) ? '0 : exp_reg;

        if (cnt_eff < CNT_W'(4))
        begin
            if (rx_byte == MAGIC[cnt_eff[1:0]])
                n_cnt = cnt_eff + CNT_W'(1);
            else if (rx_byte == MAGIC[0])
                n_cnt = CNT_W'(1);
            else
                n_cnt = '0;
        end
        else
        begin
            n_cnt = cnt_eff + CNT_W'(1);
        end

        crc_src   = (n_cnt == CNT_W'(1)) ? CRC_INIT : crc0_reg;
        crc0_next = crc16_byte(crc_src, rx_byte);

        for (int k = 0; k < HDR_N; k++)
        begin
            hdr_next[k] = (cnt_eff == CNT_W'(k + HDR_FIRST)) ? rx_byte : hdr_reg[k];
        end

        cmd      = hdr_next[1];
        nl       = hdr_next[14];
        pl       = {hdr_next[13], hdr_next[12]};
        drop     = 1'b0;
        exp_next = exp_eff;

        if (n_cnt >= CNT_W'(6) && exp_eff == '0)
        begin
            if (cmd == cfg.start_code && n_cnt >= CNT_W'(START_FIXED))
            begin
                if (nl > 8'(MAX_NAME))
                    drop = 1'b1;
                else
                    exp_next = CNT_W'(START_FIXED + 2) + CNT_W'(nl);
            end
            else if (cmd == cfg.data_code && n_cnt >= CNT_W'(DATA_FIXED))
            begin
                if (pl == 16'd0 || pl > 16'(MAX_CHUNK))
                    drop = 1'b1;
                else
                    exp_next = CNT_W'(DATA_FIXED + 2) + CNT_W'(pl);
            end
            else if (cmd == cfg.end_code)
            begin
                exp_next = CNT_W'(END_LEN);
            end
            else if (cmd == cfg.format_code)
            begin
                exp_next = CNT_W'(FORMAT_LEN);
            end
            else if (cmd != cfg.start_code && cmd != cfg.data_code)
            begin
                drop = 1'b1;
            end
        end

        done = !drop && exp_next != '0 && n_cnt >= exp_next;

        if (drop || done)
            count_next = '0;
        else
            count_next = n_cnt;

        desc_new.ver    = hdr_next[0];
        desc_new.cmd    = hdr_next[1];
        desc_new.id     = {hdr_next[3], hdr_next[2]};
        desc_new.w8     = {hdr_next[7], hdr_next[6], hdr_next[5], hdr_next[4]};
        desc_new.w12    = {hdr_next[11], hdr_next[10], hdr_next[9], hdr_next[8]};
        desc_new.w16    = {hdr_next[13], hdr_next[12]};
        desc_new.b18    = hdr_next[14];
        desc_new.len    = 8'(exp_next);
        desc_new.crc_ok = (crc1_reg == {rx_byte, prev_reg});
    end

    // Parser control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            exp_reg    <= '0;
            crc0_reg   <= CRC_INIT;
            crc1_reg   <= CRC_INIT;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                exp_reg   <= (drop || done) ? '0 : exp_next;
                crc0_reg  <= crc0_next;
                crc1_reg  <= crc0_reg;
                if (done)
                    wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (desc_pop && desc_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            q_cnt_reg <= q_cnt_reg + 2'(accept && done) - 2'(desc_pop && desc_valid);
        end
    end

    // Header bytes, packet slots and payload memory.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_reg <= rx_byte;
            for (int k = 0; k < HDR_N; k++)
            begin
                hdr_reg[k] <= hdr_next[k];
            end
            if (cnt_eff >= CNT_W'(DATA_FIXED))
                pay_mem[{wr_ptr_reg, PW'(cnt_eff - CNT_W'(DATA_FIXED))}] <= rx_byte;
            if (done)
                slot_reg[wr_ptr_reg] <= desc_new;
        end
        pay_data_reg <= pay_mem[{rd_ptr_reg, pay_idx}];
    end

    // The store never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STORE_CAP))
        else $error("packet byte count beyond store capacity");

    // A known length is always still ahead of the byte count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg != '0) |-> (count_reg < exp_reg))
        else $error("packet length reached without dispatch");

    // The executor only takes packets that are queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_pop |-> (q_cnt_reg != 2'd0))
        else $error("packet taken from an empty queue");

endmodule

`default_nettype wire

// ----- design/fcpr_back.sv -----
// Protocol executor: checks each complete packet against the transfer state,
// updates that state and emits payload bytes and replies. Depends on fcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcpr_back #(
    parameter int unsigned MAX_CHUNK = fcpr_pkg::DEF_MAX_CHUNK,
    parameter int unsigned MAX_NAME  = fcpr_pkg::DEF_MAX_NAME,
    parameter int unsigned PW        = $clog2(MAX_CHUNK + 2)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fcpr_pkg::cfg_t    cfg,
    input  wire logic              desc_valid,
    input  wire fcpr_pkg::desc_t   desc,
    output logic                   desc_pop,
    output logic [PW-1:0]          pay_idx,
    input  wire logic [7:0]        pay_data,
    output logic                   res_push,
    output fcpr_pkg::result_t      res,
    input  wire logic              res_full
);
    import fcpr_pkg::*;

    back_state_t state_reg, state_next;

    // Transfer state.
    logic        open_reg, open_next;
    logic [15:0] cur_id_reg, cur_id_next;
    logic [31:0] dsize_reg, dsize_next;
    logic [31:0] dcrc_reg, dcrc_next;
    logic [15:0] chunk_reg, chunk_next;
    logic [31:0] nseq_reg, nseq_next;
    logic [31:0] noff_reg, noff_next;

    // Reply and payload walk.
    kind_t       r_kind_reg, r_kind_next;
    status_t     r_stat_reg, r_stat_next;
    logic [15:0] r_id_reg, r_id_next;
    logic [31:0] r_seq_reg, r_seq_next;
    logic [PW-1:0] pay_cnt_reg, pay_cnt_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [31:0] off_reg, off_next;

    logic        ver_ok, reply, payload;
    logic [32:0] end_sum;
    logic [15:0] start_len;

    assign pay_idx = idx_reg;

    always_comb
    begin
        state_next   = state_reg;
        open_next    = open_reg;
        cur_id_next  = cur_id_reg;
        dsize_next   = dsize_reg;
        dcrc_next    = dcrc_reg;
        chunk_next   = chunk_reg;
        nseq_next    = nseq_reg;
        noff_next    = noff_reg;
        r_kind_next  = r_kind_reg;
        r_stat_next  = r_stat_reg;
        r_id_next    = r_id_reg;
        r_seq_next   = r_seq_reg;
        pay_cnt_next = pay_cnt_reg;
        idx_next     = idx_reg;
        off_next     = off_reg;
        desc_pop     = 1'b0;
        res_push     = 1'b0;
        reply        = 1'b0;
        payload      = 1'b0;

        ver_ok    = (desc.ver == cfg.version);
        end_sum   = {1'b0, desc.w12} + {17'd0, desc.w16};
        start_len = 16'(START_FIXED + 2) + {8'd0, desc.b18};

        res.kind        = r_kind_reg;
        res.file_id     = r_id_reg;
        res.seq         = r_seq_reg;
        res.status      = r_stat_reg;
        res.data_byte   = 8'd0;
        res.byte_offset = 32'd0;
        res.last        = 1'b1;
        res.receiving   = open_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (desc_valid)
                begin
                    r_kind_next = KIND_NACK;
                    r_stat_next = STAT_OK;
                    r_id_next   = 16'd0;
                    r_seq_next  = 32'd0;

                    // Command decode in the same order as the parser.
                    if (desc.cmd == cfg.start_code)
                    begin
                        reply = 1'b1;
                        if (!desc.crc_ok)
                            r_stat_next = STAT_CRC;
                        else if (desc.len < 8'(START_FIXED + 2) || !ver_ok)
                            r_stat_next = STAT_PARAM;
                        else if (desc.b18 > 8'(MAX_NAME) || {8'd0, desc.len} != start_len)
                        begin
                            r_id_next   = desc.id;
                            r_stat_next = STAT_PARAM;
                        end
                        else
                        begin
                            r_id_next   = desc.id;
                            cur_id_next = desc.id;
                            dsize_next  = desc.w8;
                            dcrc_next   = desc.w12;
                            chunk_next  = desc.w16;
                            if (desc.w8 == 32'd0 || desc.w16 == 16'd0 ||
                                desc.w16 > 16'(MAX_CHUNK))
                                r_stat_next = STAT_PARAM;
                            else
                            begin
                                open_next   = 1'b1;
                                nseq_next   = 32'd0;
                                noff_next   = 32'd0;
                                r_kind_next = KIND_ACK;
                            end
                        end
                    end
                    else if (desc.cmd == cfg.data_code)
                    begin
                        r_id_next  = desc.id;
                        r_seq_next = desc.w8;
                        if (desc.len >= 8'(DATA_FIXED + 2))
                        begin
                            reply = 1'b1;
                            if (!desc.crc_ok)
                                r_stat_next = STAT_CRC;
                            else if (!open_reg || desc.id != cur_id_reg || !ver_ok ||
                                     desc.w16 == 16'd0 || desc.w16 > chunk_reg ||
                                     desc.w16 > 16'(MAX_CHUNK) ||
                                     {8'd0, desc.len} != 16'(DATA_FIXED + 2) + desc.w16)
                                r_stat_next = STAT_PARAM;
                            else if (desc.w8 != nseq_reg)
                                r_stat_next = STAT_SEQ;
                            else if (desc.w12 != noff_reg)
                                r_stat_next = STAT_OFFSET;
                            else if (end_sum > {1'b0, dsize_reg})
                                r_stat_next = STAT_PARAM;
                            else
                            begin
                                payload      = 1'b1;
                                r_kind_next  = KIND_ACK;
                                noff_next    = end_sum[31:0];
                                nseq_next    = nseq_reg + 32'd1;
                                pay_cnt_next = PW'(desc.w16);
                                idx_next     = '0;
                                off_next     = desc.w12;
                            end
                        end
                    end
                    else if (desc.cmd == cfg.end_code)
                    begin
                        reply      = 1'b1;
                        r_id_next  = desc.id;
                        r_seq_next = desc.w8;
                        if (!desc.crc_ok)
                            r_stat_next = STAT_CRC;
                        else if (!open_reg || !ver_ok || desc.id != cur_id_reg)
                            r_stat_next = STAT_PARAM;
                        else
                        begin
                            open_next = 1'b0;
                            if (desc.w8 != nseq_reg || desc.w12 != dcrc_reg ||
                                noff_reg != dsize_reg)
                                r_stat_next = STAT_FILE;
                            else
                                r_kind_next = KIND_ACK;
                        end
                    end
                    else if (desc.cmd == cfg.format_code)
                    begin
                        r_id_next = desc.id;
                        if (desc.len == 8'(FORMAT_LEN) && ver_ok)
                        begin
                            reply = 1'b1;
                            if (!desc.crc_ok)
                                r_stat_next = STAT_CRC;
                            else
                            begin
                                open_next   = 1'b0;
                                r_kind_next = KIND_ACK;
                            end
                        end
                    end

                    if (payload)
                        state_next = S_READ;
                    else if (reply)
                        state_next = S_REPLY;
                    else
                        desc_pop = 1'b1;
                end
            end

            // Address the payload memory; the registered byte is used in S_WRITE.
            S_READ:
            begin
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                res.kind        = KIND_DATA;
                res.status      = STAT_OK;
                res.data_byte   = pay_data;
                res.byte_offset = off_reg;
                res.last        = 1'b0;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    off_next = off_reg + 32'd1;
                    if (idx_reg == pay_cnt_reg - PW'(1))
                        state_next = S_REPLY;
                    else
                    begin
                        idx_next   = idx_reg + PW'(1);
                        state_next = S_READ;
                    end
                end
            end

            S_REPLY:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    desc_pop   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            open_reg   <= 1'b0;
            cur_id_reg <= 16'd0;
            dsize_reg  <= 32'd0;
            dcrc_reg   <= 32'd0;
            chunk_reg  <= 16'd0;
            nseq_reg   <= 32'd0;
            noff_reg   <= 32'd0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            open_reg   <= open_next;
            cur_id_reg <= cur_id_next;
            dsize_reg  <= dsize_next;
            dcrc_reg   <= dcrc_next;
            chunk_reg  <= chunk_next;
            nseq_reg   <= nseq_next;
            noff_reg   <= noff_next;
            idx_reg    <= idx_next;
        end
    end

    // Reply payload registers.
    always_ff @(posedge clk)
    begin
        r_kind_reg  <= r_kind_next;
        r_stat_reg  <= r_stat_next;
        r_id_reg    <= r_id_next;
        r_seq_reg   <= r_seq_next;
        pay_cnt_reg <= pay_cnt_next;
        off_reg     <= off_next;
    end

    // A payload walk always has at least one byte to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (pay_cnt_reg != '0))
        else $error("payload walk with empty chunk");

    // Results never enter a full result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    // A packet is only released while one is queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_pop |-> desc_valid)
        else $error("packet released while none is queued");

endmodule

`default_nettype wire

// ----- design/fcpr_out_fifo.sv -----
// Result queue between the executor and the result ports.
// Depends on fcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcpr_out_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire fcpr_pkg::result_t  wr_data,
    output logic                    wr_full,
    output logic                    empty,
    input  wire logic               pop,
    output fcpr_pkg::result_t       rd_data
);
    import fcpr_pkg::*;

    localparam int unsigned AW = $clog2(OUT_DEPTH);

    result_t         fifo_reg [OUT_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     cnt_reg;
    logic            do_wr, do_rd;

    assign wr_full = (cnt_reg == (AW+1)'(OUT_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !wr_full;
    assign do_rd   = pop && !empty;
    assign rd_data = fifo_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            fifo_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ----- design/file_chunk_packet_receiver.sv -----
// File chunk packet receiver. Each item is one link byte, taken while push is high
// and full is low. A parser checks the magic, decodes the packet length and the
// CRC as bytes arrive and queues each complete packet in one of two slots; an
// executor then judges a packet, walks each payload byte of a DATA chunk
// (payload memory read, then write into the result queue) and sends the reply,
// waiting while the result queue is full. full rises only while both packet
// slots are waiting on the executor. Results leave through a four-entry queue
// on empty and pop.
// Top level; depends on fcpr_pkg, fcpr_front, fcpr_back and fcpr_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

module file_chunk_packet_receiver #(
    parameter int unsigned MAX_CHUNK = fcpr_pkg::DEF_MAX_CHUNK,
    parameter int unsigned MAX_NAME  = fcpr_pkg::DEF_MAX_NAME
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        push,
    output logic             full,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [15:0]      file_id,
    output logic [31:0]      seq,
    output logic [2:0]       status,
    output logic [7:0]       data_byte,
    output logic [31:0]      byte_offset,
    output logic             last,
    output logic             receiving
);
    import fcpr_pkg::*;

    localparam int unsigned PW = $clog2(MAX_CHUNK + 2);

    cfg_t          cfg_reg;
    logic          desc_valid, desc_pop;
    desc_t         desc;
    logic [PW-1:0] pay_idx;
    logic [7:0]    pay_data;
    logic          res_push, res_full;
    result_t       res, head;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.version     <= RST_VERSION;
            cfg_reg.start_code  <= RST_START;
            cfg_reg.data_code   <= RST_DATA;
            cfg_reg.end_code    <= RST_END;
            cfg_reg.format_code <= RST_FORMAT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_VERSION: cfg_reg.version     <= cfg_data;
                CFG_START:   cfg_reg.start_code  <= cfg_data;
                CFG_DATA:    cfg_reg.data_code   <= cfg_data;
                CFG_END:     cfg_reg.end_code    <= cfg_data;
                CFG_FORMAT:  cfg_reg.format_code <= cfg_data;
                default:     cfg_reg             <= cfg_reg;
            endcase
        end
    end

    fcpr_front #(
        .MAX_CHUNK (MAX_CHUNK),
        .MAX_NAME  (MAX_NAME),
        .PW        (PW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .push       (push),
        .full       (full),
        .cfg        (cfg_reg),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_pop   (desc_pop),
        .pay_idx    (pay_idx),
        .pay_data   (pay_data)
    );

    fcpr_back #(
        .MAX_CHUNK (MAX_CHUNK),
        .MAX_NAME  (MAX_NAME),
        .PW        (PW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_pop   (desc_pop),
        .pay_idx    (pay_idx),
        .pay_data   (pay_data),
        .res_push   (res_push),
        .res        (res),
        .res_full   (res_full)
    );

    fcpr_out_fifo u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .wr_full (res_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (head)
    );

    // Result ports.
    assign kind        = head.kind;
    assign file_id     = head.file_id;
    assign seq         = head.seq;
    assign status      = head.status;
    assign data_byte   = head.data_byte;
    assign byte_offset = head.byte_offset;
    assign last        = head.last;
    assign receiving   = head.receiving;

endmodule

`default_nettype wire
